// ===== rtl/mrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// request builder and reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int BEAT_W      = 4;

    localparam logic [7:0]  LEN_BYTE  = 8'h07;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // request beats
    localparam logic [BEAT_W-1:0] BEAT_LEN     = 4'd0;
    localparam logic [BEAT_W-1:0] BEAT_ADDR    = 4'd1;
    localparam logic [BEAT_W-1:0] BEAT_FUNC    = 4'd2;
    localparam logic [BEAT_W-1:0] BEAT_REG_HI  = 4'd3;
    localparam logic [BEAT_W-1:0] BEAT_REG_LO  = 4'd4;
    localparam logic [BEAT_W-1:0] BEAT_CNT_HI  = 4'd5;
    localparam logic [BEAT_W-1:0] BEAT_CNT_LO  = 4'd6;
    localparam logic [BEAT_W-1:0] BEAT_CRC_LO  = 4'd7;
    localparam logic [BEAT_W-1:0] BEAT_CRC_HI  = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR = 2'd0,
        CFG_FUNC_CODE  = 2'd1,
        CFG_MAX_LEN    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_TX = 1'b0,
        KIND_RX = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_CRC_ERR   = 3'd4,
        ST_BUF_FULL  = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] first_register;
        logic [15:0] register_count;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       last;
        t_status    status;
        logic [7:0] payload_total;
    } t_out_item;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic        is_send;
        logic [15:0] first_register;
        logic [15:0] register_count;
        logic [7:0]  slave_addr;
        logic [7:0]  func_code;
        t_status     status;
        logic [7:0]  payload_total;
    } t_job;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mrc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_front
// Accepts items, holds configuration and reply state, checks each reply byte
// and queues one job per item for the back end.
// ----------------------------------------------------------------------------
module mrc_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [mrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [7:0]                         i_cfg_data,
    input  wire                                i_in_valid,
    input  mrc_pkg::t_in_item                  i_in_data,
    output logic                               o_in_stall,
    output logic                               o_push,
    output mrc_pkg::t_job                      o_push_data,
    input  wire                                i_full
);
    import mrc_pkg::*;

    logic [7:0]  r_slave_addr, r_func_code, r_max_len;
    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_rbc, n_rbc;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_first, n_crc_first;
    logic        r_open, n_open;

    logic        accept;
    logic [7:0]  c;
    logic [8:0]  lim_cur, lim_new, pos_inc, cap;
    logic [8:0]  total_cur, total_new;
    logic        good;
    t_status     st;
    logic [7:0]  total;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign c          = i_in_data.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'd1;
            r_func_code  <= 8'd4;
            r_max_len    <= BYTE_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                CFG_FUNC_CODE:  r_func_code  <= i_cfg_data;
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_rbc       = r_rbc;
        n_crc       = r_crc;
        n_crc_first = r_crc_first;
        n_open      = r_open;
        st          = ST_ACCEPTED;

        lim_cur   = 9'd3 + {1'b0, r_rbc};
        total_cur = (r_pos < lim_cur) ? r_pos : lim_cur;
        total     = total_cur[7:0];

        pos_inc   = r_pos + 9'd1;
        n_rbc     = (r_pos == 9'd2) ? c : r_rbc;
        lim_new   = 9'd3 + {1'b0, n_rbc};
        total_new = (pos_inc < lim_new) ? pos_inc : lim_new;
        cap       = (r_max_len == 8'd0) ? 9'd1 : {1'b0, r_max_len};
        good      = (r_crc_first == r_crc[7:0]) && (c == r_crc[15:8]);
        n_rbc     = r_rbc;

        if (i_in_data.opcode == OP_SEND) begin
            n_pos       = '0;
            n_rbc       = '0;
            n_crc       = CRC_SEED;
            n_crc_first = '0;
            n_open      = 1'b1;
            total       = '0;
        end else if (!r_open) begin
            st = ST_IGNORED;
        end else if (r_pos == 9'd0 && c != r_slave_addr) begin
            n_open = 1'b0;
            st     = ST_BAD_ADDR;
        end else if (r_pos == 9'd1 && c != r_func_code) begin
            n_open = 1'b0;
            st     = ST_BAD_FUNC;
        end else if (r_pos >= 9'd3 && r_pos == lim_cur + 9'd1) begin
            n_open = 1'b0;
            st     = good ? ST_OK : ST_CRC_ERR;
        end else begin
            if (r_pos == 9'd2) begin
                n_rbc = c;
            end
            // first trailing CRC byte is held aside, not hashed
            if (r_pos >= 9'd3 && r_pos == lim_cur) begin
                n_crc_first = c;
            end else begin
                n_crc = crc_step(r_crc, c);
            end
            n_pos = pos_inc;
            total = total_new[7:0];
            if (pos_inc >= cap) begin
                n_open = 1'b0;
                st     = ST_BUF_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_rbc       <= '0;
            r_crc       <= CRC_SEED;
            r_crc_first <= '0;
            r_open      <= 1'b0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_rbc       <= n_rbc;
            r_crc       <= n_crc;
            r_crc_first <= n_crc_first;
            r_open      <= n_open;
        end
    end

    assign o_push = accept;

    always_comb begin
        o_push_data.is_send        = (i_in_data.opcode == OP_SEND);
        o_push_data.first_register = i_in_data.first_register;
        o_push_data.register_count = i_in_data.register_count;
        o_push_data.slave_addr     = r_slave_addr;
        o_push_data.func_code      = r_func_code;
        o_push_data.status         = st;
        o_push_data.payload_total  = total;
    end

endmodule
`default_nettype wire

// ===== rtl/mrc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_queue
// Short FIFO of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mrc_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  mrc_pkg::t_job  i_push_data,
    output logic           o_full,
    input  wire            i_pop,
    output mrc_pkg::t_job  o_head,
    output logic           o_empty
);
    import mrc_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_back
// Drains queued jobs into output beats: nine request bytes with a serial
// CRC for a send, one status beat for a reply byte.
// ----------------------------------------------------------------------------
module mrc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mrc_pkg::t_job       i_head,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output mrc_pkg::t_out_item  o_out_data
);
    import mrc_pkg::*;

    logic                r_valid;
    t_out_item           r_out, n_out;
    logic [BEAT_W-1:0]   r_beat, n_beat;
    logic [15:0]         r_crc, n_crc;
    logic                load;
    logic [7:0]          byte_sel;

    assign load = !r_valid || !i_out_stall;

    always_comb begin
        case (r_beat)
            BEAT_LEN:    byte_sel = LEN_BYTE;
            BEAT_ADDR:   byte_sel = i_head.slave_addr;
            BEAT_FUNC:   byte_sel = i_head.func_code;
            BEAT_REG_HI: byte_sel = i_head.first_register[15:8];
            BEAT_REG_LO: byte_sel = i_head.first_register[7:0];
            BEAT_CNT_HI: byte_sel = i_head.register_count[15:8];
            BEAT_CNT_LO: byte_sel = i_head.register_count[7:0];
            BEAT_CRC_LO: byte_sel = r_crc[7:0];
            BEAT_CRC_HI: byte_sel = r_crc[15:8];
            default:     byte_sel = '0;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        n_beat = r_beat;
        n_crc  = r_crc;
        n_out  = r_out;
        if (load && !i_empty) begin
            if (i_head.is_send) begin
                n_out.kind          = KIND_TX;
                n_out.tx_byte       = byte_sel;
                n_out.last          = (r_beat == BEAT_CRC_HI);
                n_out.status        = ST_ACCEPTED;
                n_out.payload_total = '0;
                // hash the six bytes after the length byte
                if (r_beat == BEAT_LEN) begin
                    n_crc = CRC_SEED;
                end else if (r_beat <= BEAT_CNT_LO) begin
                    n_crc = crc_step(r_crc, byte_sel);
                end
                if (r_beat == BEAT_CRC_HI) begin
                    o_pop  = 1'b1;
                    n_beat = BEAT_LEN;
                end else begin
                    n_beat = r_beat + BEAT_W'(1);
                end
            end else begin
                n_out.kind          = KIND_RX;
                n_out.tx_byte       = '0;
                n_out.last          = 1'b0;
                n_out.status        = i_head.status;
                n_out.payload_total = i_head.payload_total;
                o_pop               = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_LEN;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_crc <= n_crc;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/modbus_rtu_request_response_checker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_request_response_checker_top
// Modbus RTU master: builds read requests with CRC-16/MODBUS and checks the
// reply byte stream.
//
// Input channel (i_in_valid / o_in_stall): a send item yields nine transmit
// beats (length byte, address, function, start, count, CRC low/high; last on
// the ninth) and opens a new reply; a receive item carries one reply byte and
// yields one status beat. Output channel (o_out_valid / i_out_stall).
// An accepted item is written into the job queue; with the output idle, its
// first beat is then loaded into the output register. Throughput: one receive
// item per cycle unless the output stalls; a send item holds the output for
// its nine beats, one beat per cycle, since the request CRC is computed one
// byte per beat in the back end. A two-entry job queue separates the checker
// from the output register, so input keeps flowing while a result waits.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect the next
// cycle; index 0 slave address, 1 function code, 2 reply buffer size.
// Reset: synchronous, active low; registers return to 1, 4, 255 and no reply
// is open. When the receiver stalls, the output beat holds and the input
// stalls once the queue is full.
// ----------------------------------------------------------------------------
module modbus_rtu_request_response_checker_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [mrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [7:0]                      i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  mrc_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output mrc_pkg::t_out_item              o_out_data
);
    import mrc_pkg::*;

    logic push, full, pop, empty;
    t_job push_data, head;

    mrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    mrc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty)
    );

    mrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
